FILE: rtl/qedbd_pkg.sv
// Shared types and constants for the four-encoder delta and button debounce block.
// Used by the lane, merge and top-level modules; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package qedbd_pkg;

  localparam int unsigned Slots        = 4;
  localparam int unsigned NumEncDefault = 4;

  localparam int unsigned PosW    = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CntW    = 32;
  localparam int unsigned DeltaW  = 11;
  localparam int unsigned MagW    = 10;
  localparam int unsigned DebW    = 16;
  localparam int unsigned LimW    = 10;

  // Config port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegDebounceMs  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegGlitchLimit = 1'd1;
  localparam logic [DebW-1:0]    DebounceReset  = 16'd50;
  localparam logic [LimW-1:0]    GlitchReset    = 10'd64;

  // Operation codes carried on the input tuser.
  localparam logic OpService = 1'b0;
  localparam logic OpSeed    = 1'b1;

  // Input tdata layout.
  localparam int unsigned InLevelLsb = Slots * PosW;
  localparam int unsigned InNowLsb   = InLevelLsb + Slots;
  localparam int unsigned InDataW    = 168;

  // Output tdata layout.
  localparam int unsigned OutPressLsb  = Slots * DeltaW;
  localparam int unsigned OutAnyLsb    = OutPressLsb + Slots;
  localparam int unsigned OutGlitchLsb = OutAnyLsb + 1;
  localparam int unsigned OutDetentLsb = OutGlitchLsb + CntW;
  localparam int unsigned OutPassLsb   = OutDetentLsb + CntW;
  localparam int unsigned OutUsedW     = OutPassLsb + CntW;
  localparam int unsigned OutDataW     = 152;

  typedef struct packed {
    logic [DebW-1:0] debounce_ms;
    logic [LimW-1:0] glitch_limit;
  } cfg_t;

  typedef struct packed {
    logic seed;   // load the cache from this item
    logic serve;  // seeded service pass: compare and update
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta;
    logic [MagW-1:0]          mag;
    logic                     glitch;
    logic                     press;
  } lane_res_t;

  typedef struct packed {
    logic load;   // a service item was accepted, a result is due
    logic serve;  // that item was taken after seeding
  } merge_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/qedbd_lane.sv
// One encoder lane: cached position, button level and last press time.
// Computes the accepted delta, glitch flag and debounced press; uses qedbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qedbd_lane (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire qedbd_pkg::lane_ctrl_t           ctrl_i,
  input  wire qedbd_pkg::cfg_t                 cfg_i,
  input  wire logic [qedbd_pkg::PosW-1:0]      pos_i,
  input  wire logic                            level_i,
  input  wire logic [qedbd_pkg::TimeW-1:0]     now_i,
  output qedbd_pkg::lane_res_t                 res_o
);

  logic [qedbd_pkg::PosW-1:0]  cached_pos_q, cached_pos_d;
  logic                        btn_down_q, btn_down_d;
  logic [qedbd_pkg::TimeW-1:0] last_press_q, last_press_d;

  logic [qedbd_pkg::PosW-1:0]  diff;
  logic [qedbd_pkg::PosW-1:0]  mag;
  logic [qedbd_pkg::TimeW-1:0] elapsed;
  logic                        glitch;
  logic                        down;
  logic                        press_ok;

  always_comb begin
    diff     = pos_i - cached_pos_q;
    mag      = diff[qedbd_pkg::PosW-1] ? (~diff + qedbd_pkg::PosW'(1)) : diff;
    glitch   = mag > {{(qedbd_pkg::PosW-qedbd_pkg::LimW){1'b0}}, cfg_i.glitch_limit};
    down     = ~level_i;
    elapsed  = now_i - last_press_q;
    press_ok = down && !btn_down_q &&
               (elapsed >= {{(qedbd_pkg::TimeW-qedbd_pkg::DebW){1'b0}}, cfg_i.debounce_ms});

    res_o.delta  = (ctrl_i.serve && !glitch) ? diff[qedbd_pkg::DeltaW-1:0] : '0;
    res_o.mag    = (ctrl_i.serve && !glitch) ? mag[qedbd_pkg::MagW-1:0] : '0;
    res_o.glitch = ctrl_i.serve && glitch;
    res_o.press  = ctrl_i.serve && press_ok;

    cached_pos_d = cached_pos_q;
    btn_down_d   = btn_down_q;
    last_press_d = last_press_q;
    if (ctrl_i.seed || ctrl_i.serve) begin
      // The cache follows the reading even when the jump was dropped.
      cached_pos_d = pos_i;
      btn_down_d   = down;
    end
    if (ctrl_i.serve && press_ok) begin
      last_press_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_pos_q <= '0;
      btn_down_q   <= 1'b0;
      last_press_q <= '0;
    end else begin
      cached_pos_q <= cached_pos_d;
      btn_down_q   <= btn_down_d;
      last_press_q <= last_press_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qedbd_merge.sv
// Merge stage: combines the lane results, keeps the glitch, detent and pass
// counters and holds the output register; uses qedbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qedbd_merge (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire qedbd_pkg::merge_ctrl_t                     ctrl_i,
  input  wire qedbd_pkg::lane_res_t [qedbd_pkg::Slots-1:0] lane_i,
  input  wire logic                                       out_ready_i,
  output logic                                            out_valid_o,
  output logic [qedbd_pkg::OutDataW-1:0]                  out_data_o
);

  localparam int unsigned GSumW = $clog2(qedbd_pkg::Slots + 1);
  localparam int unsigned DSumW = qedbd_pkg::MagW + $clog2(qedbd_pkg::Slots + 1);

  logic [qedbd_pkg::CntW-1:0]     glitch_q, glitch_d;
  logic [qedbd_pkg::CntW-1:0]     detent_q, detent_d;
  logic [qedbd_pkg::CntW-1:0]     pass_q, pass_d;
  logic                           out_valid_q, out_valid_d;
  logic [qedbd_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic [GSumW-1:0]         gsum;
  logic [DSumW-1:0]         dsum;
  logic [qedbd_pkg::Slots-1:0] press_mask;
  logic                     any_delta;
  logic                     any_event;

  always_comb begin
    gsum       = '0;
    dsum       = '0;
    any_delta  = 1'b0;
    press_mask = '0;
    for (int i = 0; i < qedbd_pkg::Slots; i++) begin
      gsum          = gsum + GSumW'(lane_i[i].glitch);
      dsum          = dsum + DSumW'(lane_i[i].mag);
      any_delta     = any_delta | (|lane_i[i].delta);
      press_mask[i] = lane_i[i].press;
    end
    any_event = any_delta | (|press_mask);

    glitch_d = glitch_q;
    detent_d = detent_q;
    pass_d   = pass_q;
    if (ctrl_i.serve) begin
      glitch_d = glitch_q + qedbd_pkg::CntW'(gsum);
      detent_d = detent_q + qedbd_pkg::CntW'(dsum);
      pass_d   = pass_q + qedbd_pkg::CntW'(1);
    end

    out_data_d = out_data_q;
    if (ctrl_i.load) begin
      out_data_d = '0;
      for (int i = 0; i < qedbd_pkg::Slots; i++) begin
        out_data_d[i*qedbd_pkg::DeltaW +: qedbd_pkg::DeltaW] = lane_i[i].delta;
      end
      out_data_d[qedbd_pkg::OutPressLsb +: qedbd_pkg::Slots] = press_mask;
      out_data_d[qedbd_pkg::OutAnyLsb]                       = any_event;
      out_data_d[qedbd_pkg::OutGlitchLsb +: qedbd_pkg::CntW] = glitch_d;
      out_data_d[qedbd_pkg::OutDetentLsb +: qedbd_pkg::CntW] = detent_d;
      out_data_d[qedbd_pkg::OutPassLsb +: qedbd_pkg::CntW]   = pass_d;
    end

    if (ctrl_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glitch_q    <= '0;
      detent_q    <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      glitch_q    <= glitch_d;
      detent_q    <= detent_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/quad_encoder_delta_button_debounce.sv
// A service item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; a new item is taken whenever the output register is empty
// or is being drained in the same cycle. Seed items produce no result.
// All encoder lanes evaluate in parallel in the accept cycle and update their state there.
// Reset clears the caches, counters and seeded flag, and loads debounce 50 ms, glitch limit 64.
// Top level: config registers, seeded flag, encoder lanes and merge stage; uses qedbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module quad_encoder_delta_button_debounce #(
  parameter int unsigned NumEncoders = qedbd_pkg::NumEncDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [qedbd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [qedbd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: position_0, position_1, position_2, position_3, switch_levels, now_ms, zero pad
  input  wire logic [qedbd_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: operation
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: delta_0, delta_1, delta_2, delta_3, pressed_mask, any_event, glitch_total,
  // detent_total, pass_total, zero pad
  output logic [qedbd_pkg::OutDataW-1:0]         m_axis_tdata
);

  qedbd_pkg::cfg_t                            cfg_q, cfg_d;
  logic                                       seeded_q, seeded_d;
  logic                                       s_fire;
  qedbd_pkg::lane_ctrl_t                      lane_ctrl;
  qedbd_pkg::merge_ctrl_t                     merge_ctrl;
  qedbd_pkg::lane_res_t [qedbd_pkg::Slots-1:0] lane_res;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    lane_ctrl.seed    = s_fire && (s_axis_tuser == qedbd_pkg::OpSeed);
    lane_ctrl.serve   = s_fire && (s_axis_tuser == qedbd_pkg::OpService) && seeded_q;
    merge_ctrl.load   = s_fire && (s_axis_tuser == qedbd_pkg::OpService);
    merge_ctrl.serve  = lane_ctrl.serve;
    seeded_d          = seeded_q || lane_ctrl.seed;

    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qedbd_pkg::RegDebounceMs:
          cfg_d.debounce_ms = cfg_data_i[qedbd_pkg::DebW-1:0];
        qedbd_pkg::RegGlitchLimit:
          cfg_d.glitch_limit = cfg_data_i[qedbd_pkg::LimW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= qedbd_pkg::DebounceReset;
      cfg_q.glitch_limit <= qedbd_pkg::GlitchReset;
      seeded_q           <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      seeded_q <= seeded_d;
    end
  end

  for (genvar g = 0; g < qedbd_pkg::Slots; g++) begin : g_lane
    if (g < NumEncoders) begin : g_used
      qedbd_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (lane_ctrl),
        .cfg_i   (cfg_q),
        .pos_i   (s_axis_tdata[g*qedbd_pkg::PosW +: qedbd_pkg::PosW]),
        .level_i (s_axis_tdata[qedbd_pkg::InLevelLsb + g]),
        .now_i   (s_axis_tdata[qedbd_pkg::InNowLsb +: qedbd_pkg::TimeW]),
        .res_o   (lane_res[g])
      );
    end else begin : g_unused
      assign lane_res[g] = '0;
    end
  end

  qedbd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (merge_ctrl),
    .lane_i      (lane_res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // A seed item never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == qedbd_pkg::OpSeed && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("seed item produced a result");

  // Every service item is followed by a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == qedbd_pkg::OpService) |=> m_axis_tvalid)
    else $error("service item lost");

  // any_event agrees with the deltas and the press mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[qedbd_pkg::OutAnyLsb] ==
      ((|m_axis_tdata[qedbd_pkg::OutPressLsb-1:0]) ||
       (|m_axis_tdata[qedbd_pkg::OutAnyLsb-1:qedbd_pkg::OutPressLsb]))))
    else $error("any_event inconsistent");

  // Before seeding, a result carries no press and no pass count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !seeded_q) |->
      (m_axis_tdata[qedbd_pkg::OutAnyLsb] == 1'b0 &&
       m_axis_tdata[qedbd_pkg::OutPassLsb +: qedbd_pkg::CntW] == '0))
    else $error("unseeded result carries events");

endmodule

`default_nettype wire

FILE: sim/qedbd_pass_checker.sv
// Checker for the four-encoder delta and button debounce block: predicts each service pass
// and compares the results in order. Depends on qedbd_pkg for widths, codes and tdata layout.
`timescale 1ns / 1ps

module qedbd_pass_checker
  import qedbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // tdata: position_0, position_1, position_2, position_3, switch_levels, now_ms, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: delta_0..delta_3, pressed_mask, any_event, glitch_total, detent_total,
  // pass_total, zero pad
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int unsigned         errors_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         presses_o,
  output int unsigned         glitches_o
);

  // Same bit order as the output tdata, lowest field last.
  typedef struct packed {
    logic [OutDataW-OutUsedW-1:0]  pad;
    logic [CntW-1:0]               pass_total;
    logic [CntW-1:0]               detent_total;
    logic [CntW-1:0]               glitch_total;
    logic                          any_event;
    logic [Slots-1:0]              pressed_mask;
    logic [Slots-1:0][DeltaW-1:0]  delta;
  } pass_result_t;

  logic [DebW-1:0]  debounce;
  logic [LimW-1:0]  limit;
  logic [PosW-1:0]  cache_pos [Slots];
  logic             btn_down [Slots];
  logic [TimeW-1:0] last_press [Slots];
  logic [CntW-1:0]  glitch_cnt;
  logic [CntW-1:0]  detent_cnt;
  logic [CntW-1:0]  pass_cnt;
  logic             seeded;

  pass_result_t pass_results_q [$];

  assign glitches_o = glitch_cnt;

  function automatic string show(pass_result_t r);
    return $sformatf("delta %0d %0d %0d %0d press %b any %b glitch %0d detent %0d pass %0d pad %h",
                     $signed(r.delta[0]), $signed(r.delta[1]), $signed(r.delta[2]),
                     $signed(r.delta[3]), r.pressed_mask, r.any_event, r.glitch_total,
                     r.detent_total, r.pass_total, r.pad);
  endfunction

  task automatic report_mismatch(input string what, input pass_result_t want,
                                 input pass_result_t got);
    errors_o++;
    if (errors_o <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", show(want));
      $display("  actual   %s", show(got));
    end
  endtask

  task automatic absorb_item(input logic [InDataW-1:0] data, input logic op);
    pass_result_t     r;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  diff;
    logic [PosW-1:0]  mag;
    logic [TimeW-1:0] elapsed;
    logic [Slots-1:0] lv;
    logic [TimeW-1:0] now;
    logic             down;
    int               i;
    lv  = data[InLevelLsb +: Slots];
    now = data[InNowLsb +: TimeW];
    r   = '0;
    if (op == OpSeed) begin
      for (i = 0; i < Slots; i++) begin
        cache_pos[i] = data[i*PosW +: PosW];
        btn_down[i]  = !lv[i];
      end
      seeded = 1'b1;
      return;
    end
    // Before the first seed a service pass reports the counters and changes nothing.
    if (seeded) begin
      pass_cnt++;
      for (i = 0; i < Slots; i++) begin
        pos  = data[i*PosW +: PosW];
        diff = pos - cache_pos[i];
        mag  = diff[PosW-1] ? (32'd0 - diff) : diff;
        if (mag > PosW'(limit)) begin
          glitch_cnt++;
          diff = '0;
          mag  = '0;
        end
        cache_pos[i] = pos;
        if (diff != '0) begin
          r.delta[i]  = diff[DeltaW-1:0];
          r.any_event = 1'b1;
          detent_cnt += mag;
        end
      end
      for (i = 0; i < Slots; i++) begin
        down    = !lv[i];
        elapsed = now - last_press[i];
        if (down && !btn_down[i] && elapsed >= TimeW'(debounce)) begin
          r.pressed_mask[i] = 1'b1;
          r.any_event       = 1'b1;
          last_press[i]     = now;
        end
        btn_down[i] = down;
      end
    end
    r.glitch_total = glitch_cnt;
    r.detent_total = detent_cnt;
    r.pass_total   = pass_cnt;
    presses_o += $countones(r.pressed_mask);
    pass_results_q.push_back(r);
    pending_o++;
  endtask

  task automatic check_result(input pass_result_t got);
    pass_result_t want;
    bit           bad;
    int           i;
    results_o++;
    if (pass_results_q.size() == 0) begin
      report_mismatch("result with no pass waiting", '0, got);
      return;
    end
    want = pass_results_q.pop_front();
    pending_o--;
    bad = 1'b0;
    for (i = 0; i < Slots; i++) begin
      if (got.delta[i] !== want.delta[i]) bad = 1'b1;
    end
    if (got.pressed_mask !== want.pressed_mask) bad = 1'b1;
    if (got.any_event !== want.any_event) bad = 1'b1;
    if (got.glitch_total !== want.glitch_total) bad = 1'b1;
    if (got.detent_total !== want.detent_total) bad = 1'b1;
    if (got.pass_total !== want.pass_total) bad = 1'b1;
    if (got.pad !== want.pad) bad = 1'b1;
    if (bad) report_mismatch("result mismatch", want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce   = DebounceReset;
      limit      = GlitchReset;
      for (int i = 0; i < Slots; i++) begin
        cache_pos[i]  = '0;
        btn_down[i]   = 1'b0;
        last_press[i] = '0;
      end
      glitch_cnt = '0;
      detent_cnt = '0;
      pass_cnt   = '0;
      seeded     = 1'b0;
      pass_results_q.delete();
      errors_o   = 0;
      pending_o  = 0;
      results_o  = 0;
      presses_o  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(pass_result_t'(m_axis_tdata));
      // An item taken at this edge still sees the register values from before it.
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tdata, s_axis_tuser);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegDebounceMs) debounce = cfg_data_i[DebW-1:0];
        else if (cfg_idx_i == RegGlitchLimit) limit = cfg_data_i[LimW-1:0];
      end
    end
  end

endmodule

FILE: sim/tb_quad_encoder_delta_button_debounce.sv
// Top of the encoder delta and debounce testbench: clock, reset, stimulus and verdict.
// Depends on qedbd_pkg, the block under test and qedbd_pass_checker.
`timescale 1ns / 1ps

module tb_quad_encoder_delta_button_debounce;
  import qedbd_pkg::*;

  localparam int unsigned InPadW = InDataW - InNowLsb - TimeW;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned presses_seen;
  int unsigned glitches_seen;

  // Stimulus bookkeeping: the readings last offered and the current register values.
  logic [Slots-1:0][PosW-1:0] gen_pos    = '0;
  logic [Slots-1:0]           gen_levels = '1;
  logic [TimeW-1:0]           gen_now    = '0;
  int unsigned cur_deb  = 50;
  int unsigned cur_lim  = 64;
  int unsigned items_sent;
  int unsigned seeds_sent;
  int unsigned settings_used = 1;

  bit sender_gaps = 1'b1;
  bit steady      = 1'b0;
  int hold_left   = 0;
  int long_hold   = 0;

  always #5 clk_i = ~clk_i;

  quad_encoder_delta_button_debounce dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  qedbd_pass_checker pass_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (fail_count),
    .pending_o     (pending),
    .results_o     (results_seen),
    .presses_o     (presses_seen),
    .glitches_o    (glitches_seen)
  );

  // Result side: random stall bursts, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      long_hold--;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic offer_item(input logic op, input logic [Slots-1:0][PosW-1:0] pos,
                            input logic [Slots-1:0] lv, input logic [TimeW-1:0] now);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{InPadW{1'b0}}, now, lv, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    gen_pos    = pos;
    gen_levels = lv;
    gen_now    = now;
    items_sent++;
    if (op == OpSeed) seeds_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned deb, input int unsigned lim);
    drain();
    write_reg(RegDebounceMs, deb);
    write_reg(RegGlitchLimit, lim);
    cur_deb = deb;
    cur_lim = lim;
    settings_used++;
  endtask

  // Mostly plausible motion around the last readings, with some glitches, seeds and
  // time jumps mixed in.
  task automatic stir_encoders(input int unsigned n);
    logic [Slots-1:0][PosW-1:0] pos;
    logic [Slots-1:0]           lv;
    logic [TimeW-1:0]           now;
    logic [PosW-1:0]            d;
    int unsigned                k;
    int                         i;
    int                         c;
    for (k = 0; k < n; k++) begin
      c = $urandom_range(0, 19);
      if (c == 0) now = $urandom();
      else if (c == 1) now = gen_now + $urandom_range(0, 70000);
      else now = gen_now + $urandom_range(0, cur_deb / 3 + 10);
      if ($urandom_range(0, 99) < 3) begin
        for (i = 0; i < Slots; i++) begin
          pos[i] = $urandom_range(0, 1) ? $urandom() : gen_pos[i] + $urandom_range(0, 15);
        end
        lv = Slots'($urandom_range(0, 15));
        offer_item(OpSeed, pos, lv, now);
      end else begin
        for (i = 0; i < Slots; i++) begin
          c = $urandom_range(0, 19);
          if (c < 5) d = '0;
          else if (c < 14) d = PosW'($urandom_range(0, 2 * cur_lim)) - cur_lim;
          else if (c < 16) d = $urandom_range(0, 1) ? cur_lim : 32'd0 - cur_lim;
          else if (c < 18) d = $urandom_range(0, 1) ? cur_lim + 1 : 32'd0 - (cur_lim + 1);
          else if (c == 18) d = $urandom();
          else d = 32'h8000_0000;
          pos[i] = gen_pos[i] + d;
          lv[i]  = gen_levels[i] ^ ($urandom_range(0, 3) == 0);
        end
        offer_item(OpService, pos, lv, now);
      end
    end
  endtask

  // Directed passes under the reset register values.
  task automatic directed_checks();
    offer_item(OpService, {32'd5, 32'd6, 32'd7, 32'd8}, 4'h0, 32'd100);
    offer_item(OpSeed, {32'h7FFF_FFFF, 32'hFFFF_FC18, 32'd1000, 32'd0}, 4'hF, 32'd0);
    // A delta right at the limit, and a step across the signed wrap point.
    offer_item(OpService, {32'h8000_0000, 32'hFFFF_FC58, 32'd999, 32'd1}, 4'hF, 32'd5);
    // One past the limit both ways, a full-range jump and an accepted -64.
    offer_item(OpService, {32'h0000_0000, 32'hFFFF_FC17, 32'd1064, 32'hFFFF_FFC1},
               4'hF, 32'd8);
    // Early presses are cached but not reported; later ones test the debounce edges.
    offer_item(OpService, gen_pos, 4'h0, 32'd10);
    offer_item(OpService, gen_pos, 4'hF, 32'd20);
    offer_item(OpService, gen_pos, 4'b1100, 32'd60);
    offer_item(OpService, gen_pos, 4'hF, 32'd70);
    offer_item(OpService, gen_pos, 4'h0, 32'd110);
    offer_item(OpService, gen_pos, 4'h0, 32'd120);
    offer_item(OpService, gen_pos, 4'hF, 32'd130);
    offer_item(OpService, gen_pos, 4'h0, 32'd159);
    offer_item(OpSeed, {32'd1234, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000}, 4'h0, 32'd160);
    offer_item(OpService, {32'd1234, 32'd0, 32'd1023, 32'h7FFF_FFFF}, 4'hF, 32'hFFFF_FFF0);
    // The clock wraps between the last press and this one.
    offer_item(OpService, gen_pos, 4'h0, 32'd16);
  endtask

  initial begin
    #5_000_000;
    $display("quad_encoder_delta_button_debounce test failed");
    $finish;
  end

  initial begin
    logic [Slots-1:0][PosW-1:0] probe;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();
    stir_encoders(280);

    set_config(0, 1023);
    probe = gen_pos;
    probe[0] += 1023;
    probe[1] -= 1023;
    probe[2] += 1024;
    probe[3] -= 1024;
    offer_item(OpService, probe, 4'h0, gen_now);
    // Hold the result side off while items keep coming, so the block backs up.
    long_hold   = 300;
    sender_gaps = 1'b0;
    stir_encoders(60);
    sender_gaps = 1'b1;
    drain();
    stir_encoders(240);

    set_config(65535, 1);
    stir_encoders(300);

    set_config(0, 0);
    probe = gen_pos;
    probe[0] += 1;
    offer_item(OpService, probe, gen_levels, gen_now);
    offer_item(OpService, gen_pos, gen_levels, gen_now);
    stir_encoders(120);

    set_config($urandom_range(0, 200), $urandom_range(1, 1023));
    stir_encoders(320);

    set_config($urandom_range(0, 65535), $urandom_range(1, 1023));
    steady      = 1'b1;
    sender_gaps = 1'b0;
    stir_encoders(300);

    drain();
    $display("Covered %0d items (%0d seeds) under %0d register settings.",
             items_sent, seeds_sent, settings_used);
    $display("Checked %0d results with %0d debounced presses and %0d dropped glitches.",
             results_seen, presses_seen, glitches_seen);
    if (fail_count == 0) begin
      $display("quad_encoder_delta_button_debounce test passed");
    end else begin
      $display("quad_encoder_delta_button_debounce test failed");
    end
    $finish;
  end

endmodule
